// ===== hdl/ss48_pkg.sv =====
// Shared types, constants and CRC helper for the 48-bit response frame checker.
// No dependencies; used by ss48_decode and safespi48_response_check_decode_unit.
package ss48_pkg;

  localparam int unsigned FrameW = 48;
  localparam int unsigned ChanW  = 3;
  localparam int unsigned ValueW = 21;

  localparam logic [7:0]        CrcPoly  = 8'h2F;
  localparam logic [7:0]        CrcInit  = 8'hFF;
  localparam logic [FrameW-1:0] ErrMask  = 48'h001E_0000_0000;
  localparam logic [FrameW-1:0] CrcSpan  = 48'hFFFF_FFFF_FF00;

  // Channel codes
  typedef enum logic [ChanW-1:0] {
    CH_GYRO_X = 3'd0,
    CH_GYRO_Y = 3'd1,
    CH_GYRO_Z = 3'd2,
    CH_ACC_X  = 3'd3,
    CH_ACC_Y  = 3'd4,
    CH_ACC_Z  = 3'd5,
    CH_TEMP   = 3'd6,
    CH_UNUSED = 3'd7
  } chan_e;

  // Decoded result of one frame, handed from decode to the output stage
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     frame_error;
    logic                     crc_error;
  } result_t;

  // Bit-serial CRC-8, MSB first. Only evaluated on constants at elaboration
  // to derive the XOR matrix columns.
  function automatic logic [7:0] crc_raw(logic [FrameW-1:0] d);
    logic [7:0] r;
    logic       top;
    r = CrcInit;
    for (int i = FrameW - 1; i >= 0; i--) begin
      top = r[7];
      r   = {r[6:0], d[i]};
      if (top) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  // Contribution of frame bit i to the CRC (the CRC is affine in the data)
  function automatic logic [7:0] crc_col(int unsigned i);
    logic [FrameW-1:0] one;
    one = '0;
    one[i] = 1'b1;
    return crc_raw(one) ^ crc_raw('0);
  endfunction

endpackage

// ===== hdl/ss48_decode.sv =====
// Combinational frame check and decode: error bits, CRC-8 as a flat XOR
// matrix, and channel-dependent value extraction. Depends on ss48_pkg.
module ss48_decode (
  input  logic [ss48_pkg::FrameW-1:0] frame_i,
  input  logic [ss48_pkg::ChanW-1:0]  channel_i,
  output ss48_pkg::result_t           result_o
);

  localparam int unsigned FrameW = ss48_pkg::FrameW;
  localparam int unsigned ValueW = ss48_pkg::ValueW;

  // CRC of the all-zero data word, the affine offset of the matrix
  localparam logic [7:0] CrcZero = ss48_pkg::crc_raw('0);

  logic [7:0]        crc_term [FrameW];
  logic [7:0]        crc_calc;
  logic [FrameW-1:0] crc_data;

  assign crc_data = frame_i & ss48_pkg::CrcSpan;

  // One constant column per frame bit, gated by that bit
  for (genvar i = 0; i < FrameW; i++) begin : g_col
    localparam logic [7:0] Col = ss48_pkg::crc_col(i);
    assign crc_term[i] = crc_data[i] ? Col : 8'h00;
  end

  // XOR reduction of independent terms, seeded with the all-zero-data CRC
  always_comb begin
    crc_calc = CrcZero;
    for (int i = 0; i < FrameW; i++) begin
      crc_calc = crc_calc ^ crc_term[i];
    end
  end

  // Value extraction: 16-bit temperature, 20-bit motion, y/z negated
  logic signed [ValueW-1:0] motion;
  logic signed [ValueW-1:0] dec_value;
  always_comb begin
    motion = ValueW'(signed'(frame_i[27:8]));
    unique case (ss48_pkg::chan_e'(channel_i))
      ss48_pkg::CH_TEMP: begin
        dec_value = ValueW'(signed'(frame_i[27:12]));
      end
      ss48_pkg::CH_GYRO_Y, ss48_pkg::CH_GYRO_Z,
      ss48_pkg::CH_ACC_Y,  ss48_pkg::CH_ACC_Z: begin
        dec_value = -motion;
      end
      default: begin
        dec_value = motion;
      end
    endcase
  end

  assign result_o.value       = dec_value;
  assign result_o.frame_error = |(frame_i & ss48_pkg::ErrMask);
  assign result_o.crc_error   = (crc_calc != frame_i[7:0]);

endmodule

// ===== hdl/safespi48_response_check_decode_unit.sv =====
// The result passes through the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled; the CRC is a
// single-level XOR matrix and the decode a short mux, so both fit between the
// input and result registers.
// Output register stalls backpressure to the input register, never dropping.
// Reset (rst_ni low, async): both stages empty, set error flag cleared.
// Top level of the response checker; depends on ss48_pkg and ss48_decode.
module safespi48_response_check_decode_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [47:0] frame
  input  logic [2:0]  s_axis_tuser,   // [2:0] channel
  input  logic        s_axis_tlast,   // last_of_set
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] value, [21] frame_error,
                                      // [22] crc_error, [23] set_ok
  output logic        m_axis_tlast    // set_done
);

  // Input register
  logic                        in_vld_q;
  logic [ss48_pkg::FrameW-1:0] frame_q;
  logic [ss48_pkg::ChanW-1:0]  chan_q;
  logic                        last_q;

  // Result register
  logic                        out_vld_q;
  ss48_pkg::result_t           res_q;
  logic                        set_ok_q;
  logic                        set_done_q;

  logic                        err_seen_q, err_seen_d;
  ss48_pkg::result_t           res_d;
  logic                        set_ok_d;
  logic                        out_adv, in_adv, s_acc;

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = in_vld_q && out_adv;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  ss48_decode u_decode (
    .frame_i   (frame_q),
    .channel_i (chan_q),
    .result_o  (res_d)
  );

  // Sticky set error, updated as each item moves into the result register
  always_comb begin
    set_ok_d   = 1'b0;
    err_seen_d = err_seen_q;
    if (in_adv) begin
      if (last_q) begin
        set_ok_d   = !(err_seen_q || res_d.frame_error || res_d.crc_error);
        err_seen_d = 1'b0;
      end else begin
        err_seen_d = err_seen_q || res_d.frame_error || res_d.crc_error;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      err_seen_q <= 1'b0;
    end else begin
      err_seen_q <= err_seen_d;
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      frame_q <= s_axis_tdata;
      chan_q  <= s_axis_tuser;
      last_q  <= s_axis_tlast;
    end
    if (in_adv) begin
      res_q      <= res_d;
      set_ok_q   <= set_ok_d;
      set_done_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {set_ok_q, res_q.crc_error, res_q.frame_error, res_q.value};
  assign m_axis_tlast  = set_done_q;

  // Assertions
  a_sticky_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && last_q) |=> !err_seen_q)
    else $error("set error flag not cleared after last item");

  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && set_ok_q) |-> set_done_q)
    else $error("set_ok raised without set_done");

  a_ok_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && set_ok_q) |-> !(res_q.crc_error || res_q.frame_error))
    else $error("set_ok raised on a faulty item");

  a_err_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && !last_q && (res_d.crc_error || res_d.frame_error)) |=> err_seen_q)
    else $error("item error not recorded in set error flag");

endmodule
